// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
// Each check is written on a line of its own with one of these macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/ddd_pkg.sv =====
package ddd_pkg;

  // Field widths of the date and result transactions.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  // Day numbers from 1 January of year 0 reach about 3.65 million.
  localparam int unsigned DNUM_W  = 23;
  // Days before the month plus leap day plus day of month.
  localparam int unsigned MPART_W = 9;

  // Division by 100 through a reciprocal: floor(x * 5243 / 2^19) is exact
  // for every x below 43690, and the largest operand here is 16782.
  localparam int unsigned        PROD_W      = 28;
  localparam int unsigned        QUOT_W      = 8;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [12:0]        RECIP_100   = 13'd5243;

  localparam logic [YEAR_W-1:0]  YEAR_MASK   = '1;
  localparam logic [6:0]         CENTURY     = 7'd100;
  localparam logic [8:0]         DAYS_COMMON = 9'd365;
  localparam logic [8:0]         CEIL_100    = 9'd99;
  localparam logic [8:0]         CEIL_400    = 9'd399;
  localparam logic [1:0]         CEIL_4      = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Load enables for the pipeline registers after the input register.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } ddd_load_t;

  // Days in the months before the given month of a common year.
  function automatic logic [MPART_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [MPART_W-1:0] days;
    unique case (m)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ===== design/ddd_day_number.sv =====
module ddd_day_number
  import ddd_pkg::*;
#(
  parameter logic [YEAR_W-1:0] YEAR_CAP = 14'd9999
) (
  input  logic                clk,
  input  ddd_load_t           load,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  output logic [DNUM_W-1:0]   day_num
);

  // Stage two: clamped date and the quotients by one hundred.
  logic [YEAR_W-1:0]  year_c;
  logic [MONTH_W-1:0] month_c;
  logic [PROD_W-1:0]  prod_f;
  logic [PROD_W-1:0]  prod_c100;
  logic [PROD_W-1:0]  prod_c400;

  logic [YEAR_W-1:0]  year2_r;
  logic [MONTH_W-1:0] month2_r;
  logic [DAY_W-1:0]   day2_r;
  logic [QUOT_W-1:0]  quot_f2_r;
  logic [QUOT_W-1:0]  quot_c100_2_r;
  logic [QUOT_W-1:0]  quot_c400_2_r;

  always_comb begin
    year_c = (year > YEAR_CAP) ? YEAR_CAP : year;
    if (month == '0) begin
      month_c = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = month;
    end
    prod_f    = PROD_W'(year_c) * PROD_W'(RECIP_100);
    prod_c100 = (PROD_W'(year_c) + PROD_W'(CEIL_100)) * PROD_W'(RECIP_100);
    prod_c400 = (PROD_W'(year_c) + PROD_W'(CEIL_400)) * PROD_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      year2_r       <= year_c;
      month2_r      <= month_c;
      day2_r        <= day;
      quot_f2_r     <= prod_f[RECIP_SHIFT +: QUOT_W];
      quot_c100_2_r <= prod_c100[RECIP_SHIFT +: QUOT_W];
      quot_c400_2_r <= prod_c400[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Stage three: days in whole years, and days within the year.
  logic [DNUM_W-1:0]  year_days;
  logic [YEAR_W-1:0]  rem100;
  logic               leap;
  logic [MPART_W-1:0] month_part;

  logic [DNUM_W-1:0]  year_days3_r;
  logic [MPART_W-1:0] month_part3_r;

  always_comb begin
    // 365 per year plus the leap years strictly before this one.
    year_days = DNUM_W'(year2_r) * DNUM_W'(DAYS_COMMON)
              + ((DNUM_W'(year2_r) + DNUM_W'(CEIL_4)) >> 2)
              - DNUM_W'(quot_c100_2_r)
              + DNUM_W'(quot_c400_2_r >> 2);
    rem100 = year2_r - YEAR_W'(quot_f2_r) * YEAR_W'(CENTURY);
    // A century year is a leap year only when its century count is a multiple of four.
    leap = ((year2_r[1:0] == 2'b00) && (rem100 != '0)) ||
           ((rem100 == '0) && (quot_f2_r[1:0] == 2'b00));
    month_part = days_before_month(month2_r)
               + MPART_W'(leap && (month2_r > MONTH_FEB))
               + MPART_W'(day2_r);
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      year_days3_r  <= year_days;
      month_part3_r <= month_part;
    end
  end

  // Stage four: the complete day number.
  logic [DNUM_W-1:0] day_num4_r;

  always_ff @(posedge clk) begin
    if (load.s4) begin
      day_num4_r <= year_days3_r + DNUM_W'(month_part3_r);
    end
  end

  assign day_num = day_num4_r;

endmodule

// ===== design/ddd_diff.sv =====
module ddd_diff
  import ddd_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [DNUM_W-1:0]   day_num_a,
  input  logic [DNUM_W-1:0]   day_num_b,
  output logic [COUNT_W-1:0]  day_count
);

  logic [DNUM_W-1:0]  gap;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  // Absolute distance, saturated to the width of the result field.
  always_comb begin
    gap = (day_num_a > day_num_b) ? (day_num_a - day_num_b) : (day_num_b - day_num_a);
    count_nxt = (gap > DNUM_W'(COUNT_MAX)) ? COUNT_MAX : gap[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      count_r <= count_nxt;
    end
  end

  assign day_count = count_r;

endmodule

// ===== design/date_day_difference.sv =====
// Distance in days between two Gregorian dates.
//
// Input channel: in_valid/in_ready carry a pair of dates, each as year,
// month and day; the dates may come in either order. Years above YEAR_MAX
// are saturated, months outside one to twelve are clamped, days are used
// as given. Output channel: out_valid/out_ready carry the absolute number
// of days between the two dates, saturated to the 22-bit field.
// The datapath is a five-register pipeline: input register, clamping and
// reciprocal division by one hundred, whole-year and in-year day counts,
// day numbers, then the distance in the output register. One transaction
// is taken every cycle for as long as the receiver keeps out_ready high.
// Each stage holds while the stage after it is full and stalled, so empty
// stages still fill while the receiver stalls; in_ready falls only once
// every stage holds a transaction. Reset empties the pipeline and drops
// any transaction in flight; there is no stored state beyond it.
module date_day_difference
  import ddd_pkg::*;
#(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [YEAR_W-1:0]   in_first_year,
  input  logic [MONTH_W-1:0]  in_first_month,
  input  logic [DAY_W-1:0]    in_first_day,
  input  logic [YEAR_W-1:0]   in_second_year,
  input  logic [MONTH_W-1:0]  in_second_month,
  input  logic [DAY_W-1:0]    in_second_day,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  out_day_count
);

  // Years on the input port never exceed the field range, so the cap fits it.
  localparam logic [YEAR_W-1:0] YEAR_CAP =
    (YEAR_MAX > int'(YEAR_MASK)) ? YEAR_MASK : YEAR_W'(YEAR_MAX);

  // Pipeline occupancy and the ready chain from the output backwards.
  logic [5:1] vld_r;
  logic [5:1] vld_nxt;
  logic [5:1] rdy;
  ddd_load_t  load;

  always_comb begin
    rdy[5] = !vld_r[5] || out_ready;
    rdy[4] = !vld_r[4] || rdy[5];
    rdy[3] = !vld_r[3] || rdy[4];
    rdy[2] = !vld_r[2] || rdy[3];
    rdy[1] = !vld_r[1] || rdy[2];

    load.s2 = rdy[2] && vld_r[1];
    load.s3 = rdy[3] && vld_r[2];
    load.s4 = rdy[4] && vld_r[3];
    load.s5 = rdy[5] && vld_r[4];

    vld_nxt[1] = rdy[1] ? in_valid : vld_r[1];
    vld_nxt[2] = rdy[2] ? vld_r[1] : vld_r[2];
    vld_nxt[3] = rdy[3] ? vld_r[2] : vld_r[3];
    vld_nxt[4] = rdy[4] ? vld_r[3] : vld_r[4];
    vld_nxt[5] = rdy[5] ? vld_r[4] : vld_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld_r[5];

  // Input register for one transaction.
  logic [YEAR_W-1:0]  year_a_r;
  logic [MONTH_W-1:0] month_a_r;
  logic [DAY_W-1:0]   day_a_r;
  logic [YEAR_W-1:0]  year_b_r;
  logic [MONTH_W-1:0] month_b_r;
  logic [DAY_W-1:0]   day_b_r;

  always_ff @(posedge clk) begin
    if (in_valid && rdy[1]) begin
      year_a_r  <= in_first_year;
      month_a_r <= in_first_month;
      day_a_r   <= in_first_day;
      year_b_r  <= in_second_year;
      month_b_r <= in_second_month;
      day_b_r   <= in_second_day;
    end
  end

  // One day-number pipeline per date.
  logic [DNUM_W-1:0] day_num_a;
  logic [DNUM_W-1:0] day_num_b;

  ddd_day_number #(
    .YEAR_CAP (YEAR_CAP)
  ) u_day_num_a (
    .clk     (clk),
    .load    (load),
    .year    (year_a_r),
    .month   (month_a_r),
    .day     (day_a_r),
    .day_num (day_num_a)
  );

  ddd_day_number #(
    .YEAR_CAP (YEAR_CAP)
  ) u_day_num_b (
    .clk     (clk),
    .load    (load),
    .year    (year_b_r),
    .month   (month_b_r),
    .day     (day_b_r),
    .day_num (day_num_b)
  );

  // Distance and output register.
  ddd_diff u_diff (
    .clk       (clk),
    .load      (load.s5),
    .day_num_a (day_num_a),
    .day_num_b (day_num_b),
    .day_count (out_day_count)
  );

  // With the output register empty every stage can move, so input is open.
`include "assert_macros.svh"
  `ASSERT_SAME(a_ready_when_drained, clk, rst_n, !vld_r[5], in_ready, "in_ready low, output empty")
  // A day number waiting in front of an empty output register moves in at once.
  `ASSERT_NEXT(a_last_stage_moves, clk, rst_n, vld_r[4] && !vld_r[5], vld_r[5], "result not loaded")
  // A full stage whose successor cannot move keeps its transaction.
  `ASSERT_NEXT(a_stage_holds, clk, rst_n, vld_r[4] && !rdy[4], vld_r[4], "stalled stage lost data")

endmodule

// ===== tb/sv/date_distance_checker.sv =====
`timescale 1ns / 100ps

module date_distance_checker
  import ddd_pkg::*;
#(
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [YEAR_W-1:0]  in_second_year,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COUNT_W-1:0] out_day_count,
  output int unsigned        mismatch_total,
  output int unsigned        awaiting_total,
  output int unsigned        compared_total
);

  localparam int unsigned PRINT_CAP = 100;

  // One accepted pair of dates together with the distance it should yield.
  typedef struct {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic [COUNT_W-1:0] distance;
  } distance_record_t;

  distance_record_t outstanding_distances[$];

  // Days that precede the given month in a common year.
  function automatic int unsigned days_ahead_of(input int unsigned month);
    case (month)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic bit leap_year(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // Absolute day index counted from the first of January of year zero.
  function automatic int unsigned day_index(input logic [YEAR_W-1:0] year_in,
                                            input logic [MONTH_W-1:0] month_in,
                                            input logic [DAY_W-1:0] day_in);
    int unsigned year;
    int unsigned month;
    int unsigned index;
    year  = year_in;
    month = month_in;
    if (year > YEAR_LIMIT) year = YEAR_LIMIT;
    if (month < MONTH_JAN) month = MONTH_JAN;
    if (month > MONTH_DEC) month = MONTH_DEC;
    // Whole years first, then the months before this one.
    index = 365 * year + (year + 3) / 4 - (year + 99) / 100 + (year + 399) / 400;
    index = index + days_ahead_of(month);
    if (month > MONTH_FEB && leap_year(year)) index = index + 1;
    return index + day_in;
  endfunction

  function automatic logic [COUNT_W-1:0] predicted_distance(input distance_record_t pair);
    int unsigned first_index;
    int unsigned second_index;
    int unsigned span;
    first_index  = day_index(pair.first_year, pair.first_month, pair.first_day);
    second_index = day_index(pair.second_year, pair.second_month, pair.second_day);
    span = (first_index > second_index) ? first_index - second_index
                                        : second_index - first_index;
    if (span > COUNT_MAX) span = COUNT_MAX;
    return span[COUNT_W-1:0];
  endfunction

  // Every discrepancy is counted; printing stops after a cap to keep the log short.
  task automatic note_mismatch(input string detail);
    mismatch_total = mismatch_total + 1;
    if (mismatch_total <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, detail);
  endtask

  // Predict on each accepted input transaction and compare each accepted result.
  always @(posedge clk) begin
    distance_record_t pair;
    if (!rst_n) begin
      outstanding_distances.delete();
      mismatch_total = 0;
      awaiting_total = 0;
      compared_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        pair.first_year   = in_first_year;
        pair.first_month  = in_first_month;
        pair.first_day    = in_first_day;
        pair.second_year  = in_second_year;
        pair.second_month = in_second_month;
        pair.second_day   = in_second_day;
        pair.distance     = '0;
        pair.distance     = predicted_distance(pair);
        outstanding_distances.push_back(pair);
      end
      if (out_valid && out_ready) begin
        if (outstanding_distances.size() == 0) begin
          note_mismatch($sformatf("day_count %0d arrived with no transaction outstanding",
                                  out_day_count));
        end else begin
          pair = outstanding_distances.pop_front();
          compared_total = compared_total + 1;
          if (out_day_count !== pair.distance) begin
            note_mismatch($sformatf("day_count %0d, expected %0d for %0d-%0d-%0d and %0d-%0d-%0d",
                                    out_day_count, pair.distance,
                                    pair.first_year, pair.first_month, pair.first_day,
                                    pair.second_year, pair.second_month, pair.second_day));
          end
        end
      end
      awaiting_total = outstanding_distances.size();
    end
  end

endmodule

// ===== tb/sv/tb_date_day_difference.sv =====
`timescale 1ns / 100ps

module tb_date_day_difference;
  import ddd_pkg::*;

  localparam int unsigned YEAR_LIMIT   = 9999;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PAIRS = 1450;
  localparam int unsigned HOLD_OFF_AT  = 200;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [YEAR_W-1:0]  in_first_year;
  logic [MONTH_W-1:0] in_first_month;
  logic [DAY_W-1:0]   in_first_day;
  logic [YEAR_W-1:0]  in_second_year;
  logic [MONTH_W-1:0] in_second_month;
  logic [DAY_W-1:0]   in_second_day;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] out_day_count;

  int unsigned mismatch_total;
  int unsigned awaiting_total;
  int unsigned compared_total;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pairs_sent;
  int unsigned quiet_cycles;

  date_day_difference #(
    .YEAR_MAX(YEAR_LIMIT)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_year   (in_first_year),
    .in_first_month  (in_first_month),
    .in_first_day    (in_first_day),
    .in_second_year  (in_second_year),
    .in_second_month (in_second_month),
    .in_second_day   (in_second_day),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_day_count   (out_day_count)
  );

  date_distance_checker #(
    .YEAR_LIMIT(YEAR_LIMIT)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_year   (in_first_year),
    .in_first_month  (in_first_month),
    .in_first_day    (in_first_day),
    .in_second_year  (in_second_year),
    .in_second_month (in_second_month),
    .in_second_day   (in_second_day),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_day_count   (out_day_count),
    .mismatch_total  (mismatch_total),
    .awaiting_total  (awaiting_total),
    .compared_total  (compared_total)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random on the falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("date_day_difference verification failed");
      $finish;
    end
  end

  function automatic cal_date_t make_date(input int unsigned year, input int unsigned month,
                                          input int unsigned day);
    cal_date_t date;
    date.year  = YEAR_W'(year);
    date.month = MONTH_W'(month);
    date.day   = DAY_W'(day);
    return date;
  endfunction

  function automatic int unsigned month_length(input int unsigned year,
                                               input int unsigned month);
    case (month)
      2: begin
        if (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)) return 29;
        return 28;
      end
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // A well-formed date in the given year; random_year favours century and range-edge years now and then.
  function automatic cal_date_t random_calendar_date(input int unsigned year);
    int unsigned month;
    month = $urandom_range(12, 1);
    return make_date(year, month, $urandom_range(month_length(year, month), 1));
  endfunction

  function automatic int unsigned random_year();
    case ($urandom_range(9))
      0:       return 400 * $urandom_range(24);
      1:       return 100 * $urandom_range(99);
      2:       return $urandom_range(3);
      3:       return YEAR_LIMIT - $urandom_range(3);
      default: return $urandom_range(YEAR_LIMIT);
    endcase
  endfunction

  // Any bit pattern the fields allow, including out-of-range values.
  function automatic cal_date_t random_raw_date();
    return make_date($urandom_range(16383), $urandom_range(15), $urandom_range(31));
  endfunction

  // Presents one pair of dates and holds it until the block takes it.
  task automatic send_pair(input cal_date_t first, input cal_date_t second);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_first_year   <= first.year;
    in_first_month  <= first.month;
    in_first_day    <= first.day;
    in_second_year  <= second.year;
    in_second_month <= second.month;
    in_second_day   <= second.day;
    do @(posedge clk); while (!in_ready);
    pairs_sent = pairs_sent + 1;
    @(negedge clk);
  endtask

  // Stimulus: reset, directed pairs, then three random phases.
  initial begin
    int unsigned k;
    int unsigned pick;
    int unsigned year;
    cal_date_t first;
    cal_date_t second;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_first_year   = '0;
    in_first_month  = '0;
    in_first_day    = '0;
    in_second_year  = '0;
    in_second_month = '0;
    in_second_day   = '0;
    send_idle_pct   = 10;
    recv_stall_pct  = 63;
    pairs_sent      = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Identical dates, the widest span, and both orders of the same pair.
    send_pair(make_date(2000, 1, 1), make_date(2000, 1, 1));
    send_pair(make_date(0, 1, 1), make_date(9999, 12, 31));
    send_pair(make_date(9999, 12, 31), make_date(0, 1, 1));
    send_pair(make_date(2024, 6, 15), make_date(1970, 1, 1));
    send_pair(make_date(1970, 1, 1), make_date(2024, 6, 15));
    // Every field at its all-ones pattern against all-zeros.
    send_pair(make_date(16383, 15, 31), make_date(0, 0, 0));
    // Years past the limit saturate to it.
    send_pair(make_date(10000, 6, 1), make_date(9999, 6, 1));
    send_pair(make_date(16383, 12, 31), make_date(9999, 12, 31));
    // Leap rules across the end of February.
    send_pair(make_date(1900, 2, 28), make_date(1900, 3, 1));
    send_pair(make_date(2000, 2, 28), make_date(2000, 3, 1));
    send_pair(make_date(2004, 2, 29), make_date(2004, 3, 1));
    send_pair(make_date(0, 2, 29), make_date(0, 3, 1));
    send_pair(make_date(2100, 3, 1), make_date(2100, 2, 28));
    send_pair(make_date(2400, 12, 31), make_date(2401, 1, 1));
    send_pair(make_date(1999, 12, 31), make_date(2001, 3, 1));
    // Months outside one to twelve are clamped.
    send_pair(make_date(1234, 0, 10), make_date(1234, 1, 10));
    send_pair(make_date(1234, 13, 10), make_date(1234, 12, 10));
    send_pair(make_date(4321, 15, 5), make_date(4320, 0, 5));
    // Day zero and days past the end of the month are used as given.
    send_pair(make_date(2023, 3, 0), make_date(2023, 2, 28));
    send_pair(make_date(2023, 4, 31), make_date(2023, 5, 1));
    send_pair(make_date(2024, 2, 31), make_date(2024, 3, 2));

    for (k = 0; k < RANDOM_PAIRS; k++) begin
      if (k == RANDOM_PAIRS / 3) begin
        send_idle_pct  = 63;
        recv_stall_pct = 10;
      end
      if (k == 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // Once, let the pipeline drain completely before sending more.
      if (k == HOLD_OFF_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (awaiting_total != 0);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        first  = random_raw_date();
        second = random_raw_date();
      end else if (pick < 40) begin
        // Close dates, so small counts and year boundaries are well covered.
        year   = random_year();
        first  = random_calendar_date(year);
        year   = (year + $urandom_range(1) > YEAR_LIMIT) ? year : year + $urandom_range(1);
        second = random_calendar_date(year);
      end else begin
        first  = random_calendar_date(random_year());
        second = random_calendar_date(random_year());
      end
      send_pair(first, second);
    end
    in_valid <= 1'b0;

    while (awaiting_total != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d date pairs and %0d compared day counts over three stall mixes.",
             pairs_sent, compared_total);
    $display("Directed pairs hit leap centuries, year zero, year saturation, month clamping "
             , "and unchecked days.");
    if (mismatch_total == 0 && awaiting_total == 0) begin
      $display("date_day_difference verification clean");
    end else begin
      $display("date_day_difference verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ddd_pkg.sv
design/ddd_day_number.sv
design/ddd_diff.sv
design/date_day_difference.sv
tb/sv/date_distance_checker.sv
tb/sv/tb_date_day_difference.sv
